// ----- hw/rtl/mwem_pkg.sv -----
// shared types and constants for the microwire eeprom master
// no dependencies; used by mwem_front, mwem_back and the top level
package mwem_pkg;

	// host command codes
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_WREN  = 3'd3,
		CMD_WRDIS = 3'd4,
		CMD_ERAL  = 3'd5
	} cmd_t;

	// microwire opcodes and fixed address patterns
	localparam logic [1:0] OP_READ  = 2'b10;
	localparam logic [1:0] OP_WRITE = 2'b01;
	localparam logic [1:0] OP_OTHER = 2'b00;
	localparam logic [1:0] PAT_WREN = 2'b11;
	localparam logic [1:0] PAT_ERAL = 2'b10;

	localparam int IDX_W = 5;
	localparam int HP_W  = 16;
	localparam int RD_W  = 8;

	// classified tick from the front part
	typedef struct packed {
		logic             start;
		logic             is_read;
		logic             pin;
		logic [IDX_W-1:0] frame_bits;
		logic [IDX_W-1:0] total_bits;
	} item_ctl_t;

	// pin levels and status for one tick
	typedef struct packed {
		logic            chip_select;
		logic            serial_clock;
		logic            serial_data;
		logic            busy;
		logic            done;
		logic [RD_W-1:0] read_data;
	} result_t;

endpackage

// ----- hw/rtl/mwem_front.sv -----
// front part: accepts ticks, decodes commands into frames, two-entry queue
// depends on mwem_pkg
module mwem_front #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [2:0]                    cmd,
	input  logic [6:0]                    addr,
	input  logic [7:0]                    wdata,
	input  logic                          data_out_pin,
	output logic                          item_valid,
	input  logic                          item_take,
	output mwem_pkg::item_ctl_t           item_ctl,
	output logic [3+ADDR_BITS+DATA_BITS-1:0] item_frame
);
	import mwem_pkg::*;

	localparam int BASE_LEN  = 3 + ADDR_BITS;
	localparam int FRAME_MAX = BASE_LEN + DATA_BITS;

	cmd_t                   cmd_c;
	logic [1:0]             op;
	logic [ADDR_BITS-1:0]   field;
	logic                   is_write;
	logic [BASE_LEN-1:0]    base;
	item_ctl_t              ctl_d;
	logic [FRAME_MAX-1:0]   frame_d;

	item_ctl_t              ctl_mem [2];
	logic [FRAME_MAX-1:0]   frame_mem [2];
	logic [1:0]             count_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic                   do_push;
	logic                   do_take;

	// command decode and frame build
	always_comb begin
		cmd_c    = cmd_t'(cmd);
		op       = OP_OTHER;
		field    = '0;
		is_write = 1'b0;
		ctl_d.start   = 1'b1;
		ctl_d.is_read = 1'b0;
		ctl_d.pin     = data_out_pin;
		unique case (cmd_c)
			CMD_READ: begin
				op = OP_READ;
				field = addr[ADDR_BITS-1:0];
				ctl_d.is_read = 1'b1;
			end
			CMD_WRITE: begin
				op = OP_WRITE;
				field = addr[ADDR_BITS-1:0];
				is_write = 1'b1;
			end
			CMD_WREN:  field = {PAT_WREN, {(ADDR_BITS-2){1'b0}}};
			CMD_WRDIS: field = '0;
			CMD_ERAL:  field = {PAT_ERAL, {(ADDR_BITS-2){1'b0}}};
			CMD_NONE:  ctl_d.start = 1'b0;
			default:   ctl_d.start = 1'b0;
		endcase
		base = {1'b1, op, field};
		frame_d = is_write ? {base, DATA_BITS'(wdata)} : {base, {DATA_BITS{1'b0}}};
		ctl_d.frame_bits = IDX_W'(BASE_LEN) + (is_write ? IDX_W'(DATA_BITS) : '0);
		ctl_d.total_bits = ctl_d.frame_bits + (ctl_d.is_read ? IDX_W'(DATA_BITS) : '0);
	end

	// queue toward the back part
	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign do_push    = push && !full;
	assign do_take    = item_valid && item_take;
	assign item_ctl   = ctl_mem[rd_ptr_q];
	assign item_frame = frame_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_mem[wr_ptr_q]   <= ctl_d;
			frame_mem[wr_ptr_q] <= frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_take) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_take) count_q <= count_q + 2'd1;
			else if (!do_push && do_take) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- hw/rtl/mwem_back.sv -----
// back part: serial clock divider, bit sequencer and result queue
// depends on mwem_pkg
module mwem_back #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mwem_pkg::HP_W-1:0]        half_period,
	input  logic                             item_valid,
	output logic                             item_take,
	input  mwem_pkg::item_ctl_t              item_ctl,
	input  logic [3+ADDR_BITS+DATA_BITS-1:0] item_frame,
	input  logic                             pop,
	output logic                             empty,
	output mwem_pkg::result_t                res
);
	import mwem_pkg::*;

	localparam int FRAME_MAX = 3 + ADDR_BITS + DATA_BITS;

	// sequencer state
	logic [HP_W-1:0]      div_q,    div_d;
	logic [IDX_W-1:0]     bit_q,    bit_d;
	logic [FRAME_MAX-1:0] frame_q,  frame_d;
	logic [DATA_BITS-1:0] rshift_q, rshift_d;
	logic                 sclk_q,   sclk_d;
	logic                 sel_q,    sel_d;
	logic                 active_q, active_d;
	logic                 op_read_q, op_read_d;
	logic [IDX_W-1:0]     fbits_q,  fbits_d;
	logic [IDX_W-1:0]     tbits_q,  tbits_d;
	logic [RD_W-1:0]      latch_q,  latch_d;
	logic                 done_d;
	logic [HP_W-1:0]      hp_eff;
	result_t              res_d;

	result_t              res_mem [2];
	logic [1:0]           count_q;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic                 out_full;
	logic                 do_pop;

	// one tick of the sequencer
	always_comb begin
		hp_eff    = (half_period == '0) ? HP_W'(1) : half_period;
		div_d     = div_q;
		bit_d     = bit_q;
		frame_d   = frame_q;
		rshift_d  = rshift_q;
		sclk_d    = sclk_q;
		sel_d     = sel_q;
		active_d  = active_q;
		op_read_d = op_read_q;
		fbits_d   = fbits_q;
		tbits_d   = tbits_q;
		latch_d   = latch_q;
		done_d    = 1'b0;
		if (!active_q) begin
			if (item_ctl.start) begin
				frame_d   = item_frame;
				rshift_d  = '0;
				op_read_d = item_ctl.is_read;
				fbits_d   = item_ctl.frame_bits;
				tbits_d   = item_ctl.total_bits;
				active_d  = 1'b1;
				sel_d     = 1'b1;
				sclk_d    = 1'b0;
				bit_d     = '0;
				div_d     = '0;
			end
		end else if (({1'b0, div_q} + 17'd1) >= {1'b0, hp_eff}) begin
			div_d = '0;
			if (sel_q) begin
				if (!sclk_q) begin
					sclk_d = 1'b1;
				end else begin
					// sample the data-out pin at the end of a high half
					if (op_read_q && (bit_q >= fbits_q))
						rshift_d = {rshift_q[DATA_BITS-2:0], item_ctl.pin};
					sclk_d  = 1'b0;
					bit_d   = bit_q + IDX_W'(1);
					frame_d = frame_q << 1;
					if (bit_d >= tbits_q) begin
						sel_d = 1'b0;
						if (op_read_q) latch_d = rshift_d[RD_W-1:0];
					end
				end
			end else begin
				active_d = 1'b0;
				done_d   = 1'b1;
			end
		end else begin
			div_d = div_q + HP_W'(1);
		end

		res_d.chip_select  = sel_d;
		res_d.serial_clock = sclk_d;
		res_d.serial_data  = (active_d && sel_d && (bit_d < fbits_d)) ?
			frame_d[FRAME_MAX-1] : 1'b0;
		res_d.busy         = active_d;
		res_d.done         = done_d;
		res_d.read_data    = latch_d;
	end

	assign out_full  = (count_q == 2'd2);
	assign item_take = item_valid && !out_full;

	// state registers advance once per taken tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q     <= '0;
			bit_q     <= '0;
			frame_q   <= '0;
			rshift_q  <= '0;
			sclk_q    <= 1'b0;
			sel_q     <= 1'b0;
			active_q  <= 1'b0;
			op_read_q <= 1'b0;
			fbits_q   <= '0;
			tbits_q   <= '0;
			latch_q   <= '0;
		end else if (item_take) begin
			div_q     <= div_d;
			bit_q     <= bit_d;
			frame_q   <= frame_d;
			rshift_q  <= rshift_d;
			sclk_q    <= sclk_d;
			sel_q     <= sel_d;
			active_q  <= active_d;
			op_read_q <= op_read_d;
			fbits_q   <= fbits_d;
			tbits_q   <= tbits_d;
			latch_q   <= latch_d;
		end
	end

	// result queue toward the consumer
	assign empty  = (count_q == 2'd0);
	assign do_pop = pop && !empty;
	assign res    = res_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (item_take) res_mem[wr_ptr_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (item_take) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)    rd_ptr_q <= ~rd_ptr_q;
			if (item_take && !do_pop) count_q <= count_q + 2'd1;
			else if (!item_take && do_pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- hw/rtl/microwire_eeprom_master_top.sv -----
// microwire eeprom master: one tick per transaction in, one pin/status result per tick out
// One input transaction is one tick of the serial engine and yields exactly one result.
// The block takes one transaction per clock cycle while the result queue has room; a
// pushed transaction is registered in the front queue, its result in the output queue
// once the back part takes it, and a two-entry queue on each side lets either end stall
// alone. The rate is set by the tick sequencer in mwem_back, which updates divider, bit
// counter and shift registers once per tick. Commands start a frame only while not
// busy; half_period (register 0, address 0) sets ticks per serial clock half, zero
// acting as one. Depends on mwem_pkg, mwem_front and mwem_back.
module microwire_eeprom_master_top #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [6:0]  addr,
	input  logic [7:0]  wdata,
	input  logic        data_out_pin,
	output logic        empty,
	input  logic        pop,
	output logic        chip_select,
	output logic        serial_clock,
	output logic        serial_data,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mwem_pkg::*;

	localparam logic REG_HALF_PERIOD = 1'b0;

	logic [HP_W-1:0]                 half_period_q;
	logic                            item_valid;
	logic                            item_take;
	item_ctl_t                       item_ctl;
	logic [3+ADDR_BITS+DATA_BITS-1:0] item_frame;
	result_t                         res;
	logic                            cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HALF_PERIOD) ? {16'b0, half_period_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HP_W'(1);
		end else if (cfg_wr && (paddr[2] == REG_HALF_PERIOD)) begin
			half_period_q <= pwdata[HP_W-1:0];
		end
	end

	// front: accept and classify
	mwem_front #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_BITS(DATA_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.addr        (addr),
		.wdata       (wdata),
		.data_out_pin(data_out_pin),
		.item_valid  (item_valid),
		.item_take   (item_take),
		.item_ctl    (item_ctl),
		.item_frame  (item_frame)
	);

	// back: tick sequencer and result queue
	mwem_back #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_BITS(DATA_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_period(half_period_q),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item_ctl   (item_ctl),
		.item_frame (item_frame),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign chip_select  = res.chip_select;
	assign serial_clock = res.serial_clock;
	assign serial_data  = res.serial_data;
	assign busy_res     = res.busy;
	assign done_res     = res.done;
	assign read_data    = res.read_data;

`ifndef SYNTHESIS
	// a finishing tick is never also busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(done_res && busy_res))
		else $error("done result while busy");

	// chip select only inside a command
	a_cs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && chip_select) |-> busy_res)
		else $error("chip select outside a command");

	// serial clock only pulses with chip select
	a_sclk_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && serial_clock) |-> chip_select)
		else $error("serial clock without chip select");

	// a taken tick always lands in the result queue next cycle
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> !empty)
		else $error("taken tick produced no result");
`endif

endmodule

// ----- sim/microwire_eeprom_master_top_tb.sv -----
// testbench for microwire_eeprom_master_top: one tick in, one pin/status result out per transaction
// predicts every tick of the serial engine and checks each result field by field
// depends on mwem_pkg and microwire_eeprom_master_top
module microwire_eeprom_master_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mwem_pkg::*;

	localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int PIN_LOW = 0;
	localparam int PIN_HIGH = 1;
	localparam int PIN_RAND = 2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] addr;
		logic [7:0] wdata;
		logic       pin;
	} tick_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  cmd;
	logic [6:0]  addr;
	logic [7:0]  wdata;
	logic        data_out_pin;
	logic        empty;
	logic        pop;
	logic        chip_select;
	logic        serial_clock;
	logic        serial_data;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	microwire_eeprom_master_top dut (.*);

	// pending ticks and expected pin levels
	tick_t   tick_q[$];
	result_t pin_exp_q[$];
	int      n_queued = 0;
	int      n_acc = 0;
	int      n_err = 0;
	int      hold_at = 0;
	int      in_gap = 0;
	int      rx_gap = 0;
	logic    in_taken = 1'b0;
	logic    out_taken = 1'b0;
	logic    rx_hold = 1'b0;
	logic    steady = 1'b0;

	// engine shadow state
	logic [15:0] hp_reg;
	logic [15:0] div_cnt;
	logic [4:0]  bit_idx;
	logic [4:0]  frm_bits;
	logic [4:0]  tot_bits;
	logic [17:0] frame_sr;
	logic [7:0]  rd_sr;
	logic [7:0]  rd_latch;
	logic        sclk_q;
	logic        cs_q;
	logic        eng_active;
	logic [2:0]  cur_op;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		n_err++;
	endtask

	// one tick of the serial engine
	task automatic eeprom_engine_tick(input tick_t t, output result_t r);
		logic [15:0] hpe;
		logic [1:0]  op;
		logic [6:0]  field;
		logic        done;
		hpe = (hp_reg == 16'd0) ? 16'd1 : hp_reg;
		done = 1'b0;
		if (!eng_active) begin
			if (t.cmd >= CMD_READ && t.cmd <= CMD_ERAL) begin
				op = OP_OTHER;
				field = 7'd0;
				case (t.cmd)
					CMD_READ: begin
						op = OP_READ;
						field = t.addr;
					end
					CMD_WRITE: begin
						op = OP_WRITE;
						field = t.addr;
					end
					CMD_WREN: field = {PAT_WREN, 5'd0};
					CMD_WRDIS: field = 7'd0;
					default: field = {PAT_ERAL, 5'd0};
				endcase
				// frame is left aligned in the shifter
				if (t.cmd == CMD_WRITE) begin
					frame_sr = {1'b1, op, field, t.wdata};
					frm_bits = 5'd18;
				end else begin
					frame_sr = {1'b1, op, field, 8'h00};
					frm_bits = 5'd10;
				end
				tot_bits = frm_bits + ((t.cmd == CMD_READ) ? 5'd8 : 5'd0);
				rd_sr = 8'd0;
				cur_op = t.cmd;
				eng_active = 1'b1;
				cs_q = 1'b1;
				sclk_q = 1'b0;
				bit_idx = 5'd0;
				div_cnt = 16'd0;
			end
		end else if ({1'b0, div_cnt} + 17'd1 >= {1'b0, hpe}) begin
			div_cnt = 16'd0;
			if (cs_q) begin
				if (!sclk_q) begin
					sclk_q = 1'b1;
				end else begin
					// end of high half: sample, advance to next bit
					if (cur_op == CMD_READ && bit_idx >= frm_bits)
						rd_sr = {rd_sr[6:0], t.pin};
					sclk_q = 1'b0;
					bit_idx = bit_idx + 5'd1;
					frame_sr = frame_sr << 1;
					if (bit_idx >= tot_bits) begin
						cs_q = 1'b0;
						if (cur_op == CMD_READ)
							rd_latch = rd_sr;
					end
				end
			end else begin
				eng_active = 1'b0;
				done = 1'b1;
			end
		end else begin
			div_cnt = div_cnt + 16'd1;
		end
		r.chip_select = cs_q;
		r.serial_clock = sclk_q;
		r.serial_data = (eng_active && cs_q && bit_idx < frm_bits) ? frame_sr[17] : 1'b0;
		r.busy = eng_active;
		r.done = done;
		r.read_data = rd_latch;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			t.cmd = CMD_NONE;
		else if (r < 42)
			t.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_B));
		else
			t.cmd = 3'($urandom_range(1, 5));
		t.addr = 7'($urandom);
		t.wdata = 8'($urandom);
		t.pin = 1'($urandom);
		return t;
	endfunction

	// monitor: check results, track config writes, predict accepted ticks
	always @(posedge clk) begin : monitor
		result_t exp_r;
		result_t got_r;
		tick_t   t;
		if (arst_n) begin
			out_taken = pop && !empty;
			in_taken = push && !full;
			if (out_taken) begin
				got_r = {chip_select, serial_clock, serial_data, busy_res, done_res, read_data};
				if (pin_exp_q.size() == 0) begin
					report_error("result transaction with no expectation waiting");
				end else begin
					exp_r = pin_exp_q.pop_front();
					if (got_r.chip_select !== exp_r.chip_select)
						report_error($sformatf("chip_select exp %b got %b",
							exp_r.chip_select, got_r.chip_select));
					if (got_r.serial_clock !== exp_r.serial_clock)
						report_error($sformatf("serial_clock exp %b got %b",
							exp_r.serial_clock, got_r.serial_clock));
					if (got_r.serial_data !== exp_r.serial_data)
						report_error($sformatf("serial_data exp %b got %b",
							exp_r.serial_data, got_r.serial_data));
					if (got_r.busy !== exp_r.busy)
						report_error($sformatf("busy_res exp %b got %b", exp_r.busy, got_r.busy));
					if (got_r.done !== exp_r.done)
						report_error($sformatf("done_res exp %b got %b", exp_r.done, got_r.done));
					if (got_r.read_data !== exp_r.read_data)
						report_error($sformatf("read_data exp %h got %h",
							exp_r.read_data, got_r.read_data));
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_HALF_PERIOD)
				hp_reg = pwdata[15:0];
			if (in_taken) begin
				t = {cmd, addr, wdata, data_out_pin};
				eeprom_engine_tick(t, exp_r);
				pin_exp_q.push_back(exp_r);
				n_acc++;
			end
		end
	end

	// driver: next tick after each accepted transaction, with random gaps
	always @(negedge clk) begin : driver
		tick_t t;
		if (arst_n && !(push && !in_taken)) begin
			if (push)
				in_gap = pick_gap();
			if (in_gap > 0) begin
				in_gap--;
				push <= 1'b0;
			end else if (tick_q.size() > 0) begin
				t = tick_q.pop_front();
				cmd <= t.cmd;
				addr <= t.addr;
				wdata <= t.wdata;
				data_out_pin <= t.pin;
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: pop with random stalls
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (out_taken)
				rx_gap = pick_gap();
			if (rx_hold || rx_gap > 0) begin
				if (rx_gap > 0)
					rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// alternate idle-free bursts with normal pacing
	initial begin : burst_pacer
		forever begin
			steady = 1'b0;
			repeat ($urandom_range(200, 600)) @(posedge clk);
			steady = 1'b1;
			repeat ($urandom_range(40, 120)) @(posedge clk);
		end
	end

	// long receiver hold-off so both queues fill and input stalls
	initial begin : rx_stall
		wait (hold_at > 0);
		while (n_acc < hold_at)
			@(posedge clk);
		rx_hold = 1'b1;
		repeat (200) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin : watchdog
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic queue_tick(input tick_t t);
		tick_q.push_back(t);
		n_queued++;
	endtask

	task automatic wait_drain();
		while (n_acc != n_queued || pin_exp_q.size() != 0)
			@(negedge clk);
	endtask

	// feed ticks until the engine is idle again
	task automatic drain_engine();
		while (eng_active) begin
			queue_tick(rand_tick());
			wait_drain();
		end
	endtask

	// apb write of the half period register, setup then access
	task automatic cfg_write(input logic [15:0] hp);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_HALF_PERIOD;
		pwdata <= {16'($urandom), hp};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one command followed by enough ticks to finish it at half period one
	task automatic issue_cmd(input logic [2:0] c, input logic [6:0] a, input logic [7:0] d,
		input int pin_mode);
		tick_t t;
		logic  live;
		live = (c >= CMD_READ && c <= CMD_ERAL);
		t = {c, a, d, (pin_mode == PIN_RAND) ? 1'($urandom) : 1'(pin_mode)};
		queue_tick(t);
		for (int i = 0; i < (live ? 40 : 3); i++) begin
			t = rand_tick();
			// commands during busy must be ignored
			if (live && i < 4)
				t.cmd = 3'($urandom_range(1, 5));
			else
				t.cmd = CMD_NONE;
			if (pin_mode != PIN_RAND)
				t.pin = 1'(pin_mode);
			queue_tick(t);
		end
	endtask

	task automatic run_phase(input logic [15:0] hp, input int n, input logic stall);
		cfg_write(hp);
		if (stall)
			hold_at = n_acc + 80;
		repeat (n) queue_tick(rand_tick());
		wait_drain();
		drain_engine();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cmd = CMD_NONE;
		addr = 7'd0;
		wdata = 8'd0;
		data_out_pin = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_HALF_PERIOD;
		pwdata = 32'd0;
		hp_reg = 16'd1;
		div_cnt = 16'd0;
		bit_idx = 5'd0;
		frm_bits = 5'd0;
		tot_bits = 5'd0;
		frame_sr = 18'd0;
		rd_sr = 8'd0;
		rd_latch = 8'd0;
		sclk_q = 1'b0;
		cs_q = 1'b0;
		eng_active = 1'b0;
		cur_op = CMD_NONE;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every command, address and data extremes, read pin all low/high
		issue_cmd(CMD_READ, 7'd0, 8'd0, PIN_LOW);
		issue_cmd(CMD_READ, 7'd127, 8'hFF, PIN_HIGH);
		issue_cmd(CMD_READ, 7'h55, 8'h00, PIN_RAND);
		issue_cmd(CMD_WRITE, 7'd127, 8'hFF, PIN_RAND);
		issue_cmd(CMD_WRITE, 7'd0, 8'h00, PIN_RAND);
		issue_cmd(CMD_WRITE, 7'h2A, 8'hA5, PIN_RAND);
		issue_cmd(CMD_WREN, 7'h7F, 8'hFF, PIN_RAND);
		issue_cmd(CMD_WRDIS, 7'h7F, 8'hFF, PIN_RAND);
		issue_cmd(CMD_ERAL, 7'h7F, 8'hFF, PIN_RAND);
		issue_cmd(CMD_SPARE_A, 7'h11, 8'h22, PIN_RAND);
		issue_cmd(CMD_SPARE_B, 7'h33, 8'h44, PIN_RAND);
		issue_cmd(CMD_NONE, 7'h7F, 8'hFF, PIN_RAND);
		wait_drain();
		drain_engine();

		// random phases over several half periods, zero acting as one
		run_phase(16'd1, 100, 1'b1);
		run_phase(16'd2, 90, 1'b0);
		run_phase(16'd0, 70, 1'b0);
		run_phase(16'd3, 90, 1'b0);
		run_phase(16'($urandom_range(4, 9)), 100, 1'b0);
		run_phase(16'd1, 90, 1'b0);

		// largest half period: the clock must hold through a short stretch
		cfg_write(16'hFFFF);
		queue_tick({CMD_ERAL, 7'($urandom), 8'($urandom), 1'($urandom)});
		repeat (60) queue_tick(rand_tick());
		wait_drain();

		repeat (20) @(negedge clk);
		if (n_err == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/mwem_pkg.sv
hw/rtl/mwem_front.sv
hw/rtl/mwem_back.sv
hw/rtl/microwire_eeprom_master_top.sv
sim/microwire_eeprom_master_top_tb.sv
